// ===== rtl/fdsu_pkg.sv =====
`timescale 1ns / 1ps
package fdsu_pkg;

    localparam int STACK_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

    localparam logic [5:0] CMD_PUSH    = 6'd0;
    localparam logic [5:0] CMD_ADD     = 6'd1;
    localparam logic [5:0] CMD_SUB     = 6'd2;
    localparam logic [5:0] CMD_MUL     = 6'd3;
    localparam logic [5:0] CMD_DIV     = 6'd4;
    localparam logic [5:0] CMD_MOD     = 6'd5;
    localparam logic [5:0] CMD_DIVMOD  = 6'd6;
    localparam logic [5:0] CMD_AND     = 6'd7;
    localparam logic [5:0] CMD_OR      = 6'd8;
    localparam logic [5:0] CMD_XOR     = 6'd9;
    localparam logic [5:0] CMD_LSHIFT  = 6'd10;
    localparam logic [5:0] CMD_RSHIFT  = 6'd11;
    localparam logic [5:0] CMD_NEGATE  = 6'd12;
    localparam logic [5:0] CMD_PRINT   = 6'd13;
    localparam logic [5:0] CMD_ABS     = 6'd14;
    localparam logic [5:0] CMD_MAX     = 6'd15;
    localparam logic [5:0] CMD_MIN     = 6'd16;
    localparam logic [5:0] CMD_DROP    = 6'd17;
    localparam logic [5:0] CMD_2DROP   = 6'd18;
    localparam logic [5:0] CMD_DUP     = 6'd19;
    localparam logic [5:0] CMD_2DUP    = 6'd20;
    localparam logic [5:0] CMD_ROT     = 6'd21;
    localparam logic [5:0] CMD_OVER    = 6'd22;
    localparam logic [5:0] CMD_2OVER   = 6'd23;
    localparam logic [5:0] CMD_SWAP    = 6'd24;
    localparam logic [5:0] CMD_2SWAP   = 6'd25;
    localparam logic [5:0] CMD_NIP     = 6'd26;
    localparam logic [5:0] CMD_TUCK    = 6'd27;
    localparam logic [5:0] CMD_INC     = 6'd28;
    localparam logic [5:0] CMD_DEC     = 6'd29;
    localparam logic [5:0] CMD_EQ      = 6'd30;
    localparam logic [5:0] CMD_ZEQ     = 6'd31;
    localparam logic [5:0] CMD_NE      = 6'd32;
    localparam logic [5:0] CMD_GT      = 6'd33;
    localparam logic [5:0] CMD_ZGT     = 6'd34;
    localparam logic [5:0] CMD_GE      = 6'd35;
    localparam logic [5:0] CMD_LT      = 6'd36;
    localparam logic [5:0] CMD_ZLT     = 6'd37;
    localparam logic [5:0] CMD_LE      = 6'd38;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_DIV0  = 2'd3;

    typedef struct packed {
        logic [5:0]         command;
        logic signed [63:0] push_value;
    } fdsu_in_t;

    typedef struct packed {
        logic signed [63:0] print_value;
        logic               print_valid;
        logic signed [63:0] top_value;
        logic [12:0]        depth_after;
        logic [1:0]         status;
    } fdsu_out_t;

    typedef struct packed {
        logic       start;
        logic       sign_q;
        logic       sign_r;
        logic [63:0] num;
        logic [63:0] den;
    } fdsu_div_req_t;

    function automatic logic [2:0] pop_cnt(input logic [5:0] c);
        case (c)
            CMD_PUSH: return 3'd0;
            CMD_NEGATE, CMD_PRINT, CMD_ABS, CMD_DROP, CMD_DUP,
            CMD_INC, CMD_DEC, CMD_ZEQ, CMD_ZGT, CMD_ZLT: return 3'd1;
            CMD_ROT: return 3'd3;
            CMD_2OVER, CMD_2SWAP: return 3'd4;
            default: return (c <= CMD_LE) ? 3'd2 : 3'd0;
        endcase
    endfunction

    function automatic logic [2:0] push_cnt(input logic [5:0] c);
        case (c)
            CMD_PRINT, CMD_DROP, CMD_2DROP: return 3'd0;
            CMD_DIVMOD, CMD_DUP, CMD_SWAP: return 3'd2;
            CMD_ROT, CMD_OVER, CMD_TUCK: return 3'd3;
            CMD_2DUP, CMD_2SWAP: return 3'd4;
            CMD_2OVER: return 3'd6;
            default: return (c <= CMD_LE) ? 3'd1 : 3'd0;
        endcase
    endfunction

endpackage

// ===== rtl/fdsu_divider.sv =====
`timescale 1ns / 1ps
module fdsu_divider (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fdsu_pkg::fdsu_div_req_t req,
    output logic                   done,
    output logic [63:0]            quot,
    output logic [63:0]            rem
);
    import fdsu_pkg::*;

    logic [6:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [63:0] q_reg, q_next;
    logic [64:0] r_reg, r_next;
    logic [63:0] d_reg, d_next;
    logic        sq_reg, sq_next, sr_reg, sr_next;
    logic [64:0] trial;
    logic [64:0] shifted;

    // one restoring step per cycle, magnitude in q_reg shifting out
    always_comb
    begin
        shifted   = {r_reg[63:0], q_reg[63]};
        trial     = shifted - {1'b0, d_reg};
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        sq_next   = sq_reg;
        sr_next   = sr_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = 7'd0;
            q_next   = req.num;
            r_next   = '0;
            d_next   = req.den;
            sq_next  = req.sign_q;
            sr_next  = req.sign_r;
        end
        else if (run_reg)
        begin
            if (trial[64])
            begin
                r_next = shifted;
                q_next = {q_reg[62:0], 1'b0};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b1};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg  <= q_next;
        r_reg  <= r_next;
        d_reg  <= d_next;
        sq_reg <= sq_next;
        sr_reg <= sr_next;
    end

    assign done = done_reg;
    assign quot = sq_reg ? (64'd0 - q_reg) : q_reg;
    assign rem  = sr_reg ? (64'd0 - r_reg[63:0]) : r_reg[63:0];

endmodule

// ===== rtl/fdsu_stack_ram.sv =====
`timescale 1ns / 1ps
module fdsu_stack_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [fdsu_pkg::ADDR_W-1:0] waddr,
    input  logic [63:0]               wdata,
    input  logic [fdsu_pkg::ADDR_W-1:0] raddr,
    output logic [63:0]               rdata
);
    import fdsu_pkg::*;

    logic [63:0] mem [STACK_DEPTH];
    logic [63:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/forth_data_stack_unit_core.sv =====
`timescale 1ns / 1ps
// Steps from accept to the strobe: bound check, a read and a capture per popped word,
// execute, one write per pushed word, write close, top reread and output; mul adds the
// partial-product steps, and div, mod and divmod wait on the radix-2 divider; a failed
// bound check goes straight to the top reread. Throughput: one word at a time, a new
// word is taken in the strobe cycle. The result strobe fires for one cycle; the receiver
// cannot stall it.
// Reset clears depth and control; stack memory contents stay undefined.
module forth_data_stack_unit_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fdsu_pkg::fdsu_in_t   in_word,
    output logic                 busy,
    output logic                 out_valid,
    output fdsu_pkg::fdsu_out_t  out_word
);
    import fdsu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_CAPT, S_EXEC, S_MUL, S_DIV, S_WRITE, S_TOP, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [5:0]          cmd_reg, cmd_next;
    logic [63:0]         imm_reg, imm_next;
    logic [63:0]         v_reg [4];
    logic [63:0]         v_next [4];
    logic [63:0]         r_reg [6];
    logic [63:0]         r_next [6];
    logic [2:0]          idx_reg, idx_next;
    logic [2:0]          np_reg, np_next, nq_reg, nq_next;
    logic [1:0]          status_reg, status_next;
    logic                pvalid_reg, pvalid_next;
    logic [63:0]         pval_reg, pval_next;
    logic                out_valid_reg, out_valid_next;
    fdsu_out_t           out_reg, out_next;
    logic                rd_pend_reg, rd_pend_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [63:0]         ram_wdata, ram_rdata;
    fdsu_div_req_t       div_req;
    logic                div_done;
    logic [63:0]         div_q, div_r;

    logic [63:0]         a, b;
    logic                lt_ba, lt_ab;
    logic [DEPTH_W:0]    need;
    logic [31:0]         mul_x, mul_y;
    logic [63:0]         mul_p;

    fdsu_stack_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fdsu_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_q),
        .rem   (div_r)
    );

    assign a     = v_reg[0];
    assign b     = v_reg[1];
    assign lt_ba = $signed(b) < $signed(a);
    assign lt_ab = $signed(a) < $signed(b);
    assign need  = {1'b0, depth_reg} - {{DEPTH_W-2{1'b0}}, np_reg}
                   + {{DEPTH_W-2{1'b0}}, nq_reg};

    // low 64 bits of the product from three 32x32 partial products:
    // low*low, then low(a)*high(b) and high(a)*low(b) shifted up
    assign mul_x = (idx_reg == 3'd2) ? a[63:32] : a[31:0];
    assign mul_y = (idx_reg == 3'd1) ? b[63:32] : b[31:0];
    assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        cmd_next       = cmd_reg;
        imm_next       = imm_reg;
        v_next         = v_reg;
        r_next         = r_reg;
        idx_next       = idx_reg;
        np_next        = np_reg;
        nq_next        = nq_reg;
        status_next    = status_reg;
        pvalid_next    = pvalid_reg;
        pval_next      = pval_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;
        rd_pend_next   = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;
        div_req        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = in_word.command;
                    imm_next    = in_word.push_value;
                    np_next     = pop_cnt(in_word.command);
                    nq_next     = push_cnt(in_word.command);
                    idx_next    = '0;
                    status_next = ST_OK;
                    pvalid_next = 1'b0;
                    pval_next   = '0;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                // check bounds, then fetch popped words top first
                if ({1'b0, depth_reg} < {{DEPTH_W-2{1'b0}}, np_reg})
                begin
                    status_next = ST_UNDER;
                    state_next  = S_TOP;
                end
                else if (need > (DEPTH_W+1)'(STACK_DEPTH))
                begin
                    status_next = ST_OVER;
                    state_next  = S_TOP;
                end
                else if (idx_reg == np_reg)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    ram_raddr    = ADDR_W'(depth_reg - DEPTH_W'(idx_reg) - 1'b1);
                    rd_pend_next = 1'b1;
                    state_next   = S_CAPT;
                end
            end
            S_CAPT:
            begin
                v_next[idx_reg[1:0]] = ram_rdata;
                idx_next             = idx_reg + 3'd1;
                state_next           = S_READ;
            end
            S_EXEC:
            begin
                idx_next   = '0;
                state_next = S_WRITE;
                r_next[0]  = '0;
                case (cmd_reg)
                    CMD_PUSH:   r_next[0] = imm_reg;
                    CMD_ADD:    r_next[0] = b + a;
                    CMD_SUB:    r_next[0] = b - a;
                    CMD_MUL:    state_next = S_MUL;
                    CMD_DIV, CMD_MOD, CMD_DIVMOD:
                    begin
                        if (a == 64'd0)
                        begin
                            status_next = ST_DIV0;
                            state_next  = S_TOP;
                        end
                        else
                        begin
                            div_req.start  = 1'b1;
                            div_req.sign_q = a[63] ^ b[63];
                            div_req.sign_r = b[63];
                            div_req.num    = b[63] ? (64'd0 - b) : b;
                            div_req.den    = a[63] ? (64'd0 - a) : a;
                            state_next     = S_DIV;
                        end
                    end
                    CMD_AND:    r_next[0] = b & a;
                    CMD_OR:     r_next[0] = b | a;
                    CMD_XOR:    r_next[0] = b ^ a;
                    CMD_LSHIFT: r_next[0] = (a < 64'd64) ? (b << a[5:0]) : 64'd0;
                    CMD_RSHIFT: r_next[0] = (a < 64'd64) ? 64'($signed(b) >>> a[5:0])
                                                         : {64{b[63]}};
                    CMD_NEGATE: r_next[0] = 64'd0 - a;
                    CMD_PRINT:
                    begin
                        pval_next   = a;
                        pvalid_next = 1'b1;
                    end
                    CMD_ABS:    r_next[0] = a[63] ? (64'd0 - a) : a;
                    CMD_MAX:    r_next[0] = lt_ba ? a : b;
                    CMD_MIN:    r_next[0] = lt_ab ? a : b;
                    CMD_DUP:
                    begin
                        r_next[0] = a;
                        r_next[1] = a;
                    end
                    CMD_2DUP:
                    begin
                        r_next[0] = b; r_next[1] = a; r_next[2] = b; r_next[3] = a;
                    end
                    CMD_ROT:
                    begin
                        r_next[0] = b; r_next[1] = a; r_next[2] = v_reg[2];
                    end
                    CMD_OVER:
                    begin
                        r_next[0] = b; r_next[1] = a; r_next[2] = b;
                    end
                    CMD_2OVER:
                    begin
                        r_next[0] = v_reg[3]; r_next[1] = v_reg[2];
                        r_next[2] = b;        r_next[3] = a;
                        r_next[4] = v_reg[3]; r_next[5] = v_reg[2];
                    end
                    CMD_SWAP:
                    begin
                        r_next[0] = a; r_next[1] = b;
                    end
                    CMD_2SWAP:
                    begin
                        r_next[0] = b; r_next[1] = a;
                        r_next[2] = v_reg[3]; r_next[3] = v_reg[2];
                    end
                    CMD_NIP:    r_next[0] = a;
                    CMD_TUCK:
                    begin
                        r_next[0] = a; r_next[1] = b; r_next[2] = a;
                    end
                    CMD_INC:    r_next[0] = a + 64'd1;
                    CMD_DEC:    r_next[0] = a - 64'd1;
                    CMD_EQ:     r_next[0] = {64{a == b}};
                    CMD_ZEQ:    r_next[0] = {64{a == 64'd0}};
                    CMD_NE:     r_next[0] = {64{a != b}};
                    CMD_GT:     r_next[0] = {64{lt_ab}};
                    CMD_ZGT:    r_next[0] = {64{$signed(a) > 64'sd0}};
                    CMD_GE:     r_next[0] = {64{!lt_ba}};
                    CMD_LT:     r_next[0] = {64{lt_ba}};
                    CMD_ZLT:    r_next[0] = {64{a[63]}};
                    CMD_LE:     r_next[0] = {64{!lt_ab}};
                    default:    r_next[0] = '0;
                endcase
            end
            S_MUL:
            begin
                // accumulate one partial product per cycle
                if (idx_reg == 3'd0)
                begin
                    r_next[0] = mul_p;
                end
                else
                begin
                    r_next[0] = r_reg[0] + {mul_p[31:0], 32'd0};
                end
                if (idx_reg == 3'd2)
                begin
                    idx_next   = '0;
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (cmd_reg == CMD_DIV)
                    begin
                        r_next[0] = div_q;
                    end
                    else
                    begin
                        r_next[0] = div_r;
                        r_next[1] = div_q;
                    end
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                // write back one pushed word per cycle above the popped base
                if (idx_reg == nq_reg)
                begin
                    depth_next = depth_reg - DEPTH_W'(np_reg) + DEPTH_W'(nq_reg);
                    state_next = S_TOP;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(depth_reg - DEPTH_W'(np_reg) + DEPTH_W'(idx_reg));
                    ram_wdata = r_reg[idx_reg];
                    idx_next  = idx_reg + 3'd1;
                end
            end
            S_TOP:
            begin
                ram_raddr    = ADDR_W'(depth_reg - 1'b1);
                rd_pend_next = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                out_next.print_value = pval_reg;
                out_next.print_valid = pvalid_reg;
                out_next.top_value   = (depth_reg != '0) ? ram_rdata : 64'd0;
                out_next.depth_after = 13'(depth_reg);
                out_next.status      = status_reg;
                out_valid_next       = 1'b1;
                state_next           = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        imm_reg    <= imm_next;
        v_reg      <= v_next;
        r_reg      <= r_next;
        idx_reg    <= idx_next;
        np_reg     <= np_next;
        nq_reg     <= nq_next;
        status_reg <= status_next;
        pvalid_reg <= pvalid_next;
        pval_reg   <= pval_next;
        out_reg    <= out_next;
    end

    assign busy      = (state_reg != S_IDLE) || rd_pend_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

// ===== rtl/fdsu_checker.sv =====
`timescale 1ns / 1ps
module fdsu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                out_valid,
    input fdsu_pkg::fdsu_out_t out_word
);
    import fdsu_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after accept");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |=> !out_valid)
        else $error("result strobe longer than one cycle");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.depth_after <= 13'(STACK_DEPTH))
        else $error("depth beyond stack size");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.depth_after == 13'd0 |-> out_word.top_value == 64'd0)
        else $error("top nonzero on empty stack");

    a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.print_valid |-> out_word.status == ST_OK)
        else $error("print flagged with error status");

endmodule

bind forth_data_stack_unit_core fdsu_checker u_fdsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .out_word  (out_word)
);
